/* src/llq_pkg.sv */
// Shared types and constants for the linked-list queue manager.
// Depends on nothing; every other file in src uses it by scoped names.
`timescale 1ns / 1ps

package llq_pkg;

  localparam int POOL_NODES = 16;
  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int LINK_W     = NODE_W + 1;
  localparam int DATA_WIDTH = 32;
  localparam int LEN_W      = 8;
  localparam int ENT_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int OPC_W      = 3;
  localparam int STAT_W     = 2;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(4);

  typedef logic [LINK_W-1:0] link_t;

  // null link sits one past the last node
  localparam link_t NIL = link_t'(POOL_NODES);

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND        = 3'd0,
    OP_REMOVE_OLDEST = 3'd1,
    OP_REMOVE_HANDLE = 3'd2,
    OP_READ_POS      = 3'd3,
    OP_CLEAR         = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_BAD   = 2'd3
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ENTRIES = 1'b0,
    CFG_MAX_LENGTH  = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_CHECK,
    DP_APP_TAKE,
    DP_APP_LINK,
    DP_REL_UNLINK,
    DP_REL_FREE,
    DP_SEL_OLDEST,
    DP_WALK_STEP,
    DP_WALK_END,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_APP_TAKE,
    S_APP_LINK,
    S_REL_UNLINK,
    S_REL_FREE,
    S_CLR_CHK,
    S_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  opcode;
    logic chk_ok;
    logic walk_done;
    logic list_empty;
    logic out_stall;
  } dp_stat_t;

  function automatic logic is_nil(link_t l);
    return l >= NIL;
  endfunction

endpackage

/* src/llq_ctrl.sv */
// Sequencer for the linked-list queue manager: steps each word through its micro-ops.
// Depends on llq_pkg; drives llq_dp through ctl_cmd_t and reads back dp_stat_t.
`timescale 1ns / 1ps

module llq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  llq_pkg::dp_stat_t stat,
  output llq_pkg::ctl_cmd_t cmd
);

  llq_pkg::state_t state_r;
  llq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= llq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      llq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = llq_pkg::S_CHECK;
      end
      llq_pkg::S_CHECK: begin
        if (!stat.chk_ok) begin
          state_nxt = llq_pkg::S_FINISH;
        end else begin
          case (stat.opcode)
            llq_pkg::OP_APPEND:        state_nxt = llq_pkg::S_APP_TAKE;
            llq_pkg::OP_REMOVE_OLDEST: state_nxt = llq_pkg::S_REL_UNLINK;
            llq_pkg::OP_REMOVE_HANDLE: state_nxt = llq_pkg::S_REL_UNLINK;
            llq_pkg::OP_READ_POS:      state_nxt = llq_pkg::S_WALK;
            llq_pkg::OP_CLEAR:         state_nxt = llq_pkg::S_CLR_CHK;
            default:                   state_nxt = llq_pkg::S_FINISH;
          endcase
        end
      end
      llq_pkg::S_APP_TAKE:   state_nxt = llq_pkg::S_APP_LINK;
      llq_pkg::S_APP_LINK:   state_nxt = llq_pkg::S_FINISH;
      llq_pkg::S_REL_UNLINK: state_nxt = llq_pkg::S_REL_FREE;
      llq_pkg::S_REL_FREE: begin
        state_nxt = (stat.opcode == llq_pkg::OP_CLEAR) ? llq_pkg::S_CLR_CHK
                                                       : llq_pkg::S_FINISH;
      end
      llq_pkg::S_CLR_CHK: begin
        state_nxt = stat.list_empty ? llq_pkg::S_FINISH : llq_pkg::S_REL_UNLINK;
      end
      llq_pkg::S_WALK: begin
        if (stat.walk_done) state_nxt = llq_pkg::S_FINISH;
      end
      llq_pkg::S_FINISH: begin
        if (!stat.out_stall) state_nxt = llq_pkg::S_IDLE;
      end
      default: state_nxt = llq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == llq_pkg::S_IDLE);
    cmd.load = (state_r == llq_pkg::S_IDLE) && in_valid;
    unique case (state_r)
      llq_pkg::S_IDLE:       cmd.op = llq_pkg::DP_IDLE;
      llq_pkg::S_CHECK:      cmd.op = llq_pkg::DP_CHECK;
      llq_pkg::S_APP_TAKE:   cmd.op = llq_pkg::DP_APP_TAKE;
      llq_pkg::S_APP_LINK:   cmd.op = llq_pkg::DP_APP_LINK;
      llq_pkg::S_REL_UNLINK: cmd.op = llq_pkg::DP_REL_UNLINK;
      llq_pkg::S_REL_FREE:   cmd.op = llq_pkg::DP_REL_FREE;
      llq_pkg::S_CLR_CHK: begin
        cmd.op = stat.list_empty ? llq_pkg::DP_IDLE : llq_pkg::DP_SEL_OLDEST;
      end
      llq_pkg::S_WALK: begin
        cmd.op = stat.walk_done ? llq_pkg::DP_WALK_END : llq_pkg::DP_WALK_STEP;
      end
      llq_pkg::S_FINISH: begin
        cmd.op = stat.out_stall ? llq_pkg::DP_IDLE : llq_pkg::DP_EMIT;
      end
      default: cmd.op = llq_pkg::DP_IDLE;
    endcase
  end

endmodule

/* src/llq_dp.sv */
// Datapath of the linked-list queue manager: link arrays, free list, record memory,
// config registers and the output register. Depends on llq_pkg; driven by llq_ctrl.
`timescale 1ns / 1ps

module llq_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  llq_pkg::ctl_cmd_t                 cmd,
  output llq_pkg::dp_stat_t                 stat,
  input  logic [llq_pkg::OPC_W-1:0]         in_opcode,
  input  logic [llq_pkg::DATA_WIDTH-1:0]    in_record_data,
  input  logic [llq_pkg::LEN_W-1:0]         in_record_length,
  input  logic [llq_pkg::NODE_W-1:0]        in_node_handle,
  input  logic [llq_pkg::NODE_W-1:0]        in_position,
  input  logic                              cfg_we,
  input  logic [llq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [llq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [llq_pkg::STAT_W-1:0]        out_status,
  output logic [llq_pkg::NODE_W-1:0]        out_handle,
  output logic [llq_pkg::DATA_WIDTH-1:0]    out_data,
  output logic [llq_pkg::LEN_W-1:0]         out_length,
  output logic [llq_pkg::LINK_W-1:0]        out_live_count,
  output logic                              out_is_empty,
  output logic                              out_is_full
);

  // latched word
  llq_pkg::op_t                     op_r;
  logic [llq_pkg::DATA_WIDTH-1:0]   data_r;
  logic [llq_pkg::LEN_W-1:0]        len_r;
  logic [llq_pkg::NODE_W-1:0]       handle_r;
  logic [llq_pkg::NODE_W-1:0]       pos_r;

  // list state
  llq_pkg::link_t                   next_link_r [llq_pkg::POOL_NODES];
  llq_pkg::link_t                   prev_link_r [llq_pkg::POOL_NODES];
  logic [llq_pkg::POOL_NODES-1:0]   busy_r;
  llq_pkg::link_t                   oldest_r;
  llq_pkg::link_t                   newest_r;
  llq_pkg::link_t                   free_top_r;
  logic [llq_pkg::LINK_W-1:0]       count_r;

  // walk cursor and pending result
  llq_pkg::link_t                   cur_r;
  logic [llq_pkg::NODE_W-1:0]       idx_r;
  llq_pkg::stat_t                   res_status_r;
  logic [llq_pkg::NODE_W-1:0]       res_handle_r;

  // record memory
  logic [llq_pkg::DATA_WIDTH-1:0]   payload_mem [llq_pkg::POOL_NODES];
  logic [llq_pkg::LEN_W-1:0]        length_mem  [llq_pkg::POOL_NODES];
  logic [llq_pkg::DATA_WIDTH-1:0]   rd_data_r;
  logic [llq_pkg::LEN_W-1:0]        rd_len_r;

  // config
  logic [llq_pkg::ENT_W-1:0]        max_entries_r;
  logic [llq_pkg::LEN_W-1:0]        max_length_r;

  // output register
  logic                             out_valid_r;
  llq_pkg::stat_t                   out_status_r;
  logic [llq_pkg::NODE_W-1:0]       out_handle_r;
  logic [llq_pkg::DATA_WIDTH-1:0]   out_data_r;
  logic [llq_pkg::LEN_W-1:0]        out_length_r;
  logic [llq_pkg::LINK_W-1:0]       out_count_r;
  logic                             out_empty_r;
  logic                             out_full_r;

  // combinational
  logic [llq_pkg::NODE_W-1:0]       cur_idx;
  llq_pkg::link_t                   cur_older;
  llq_pkg::link_t                   cur_newer;
  logic [llq_pkg::LINK_W-1:0]       cap;
  llq_pkg::stat_t                   chk_status;
  logic                             walk_done;
  logic                             read_ok;
  logic                             nl_we;
  logic [llq_pkg::NODE_W-1:0]       nl_addr;
  llq_pkg::link_t                   nl_data;
  logic                             pl_we;
  logic [llq_pkg::NODE_W-1:0]       pl_addr;
  llq_pkg::link_t                   pl_data;

  assign cur_idx   = cur_r[llq_pkg::NODE_W-1:0];
  assign cur_older = prev_link_r[cur_idx];
  assign cur_newer = next_link_r[cur_idx];
  assign walk_done = (idx_r == pos_r) || llq_pkg::is_nil(cur_r);
  assign read_ok   = (op_r == llq_pkg::OP_READ_POS) && (res_status_r == llq_pkg::STAT_OK);

  always_comb begin
    if ((max_entries_r == '0) ||
        (llq_pkg::LINK_W'(max_entries_r) > llq_pkg::LINK_W'(llq_pkg::POOL_NODES))) begin
      cap = llq_pkg::LINK_W'(llq_pkg::POOL_NODES);
    end else begin
      cap = llq_pkg::LINK_W'(max_entries_r);
    end
  end

  always_comb begin
    chk_status = llq_pkg::STAT_OK;
    case (op_r)
      llq_pkg::OP_APPEND: begin
        if ((count_r >= cap) || llq_pkg::is_nil(free_top_r)) begin
          chk_status = llq_pkg::STAT_FULL;
        end else if (len_r > max_length_r) begin
          chk_status = llq_pkg::STAT_BAD;
        end
      end
      llq_pkg::OP_REMOVE_OLDEST: begin
        if ((count_r == '0) || llq_pkg::is_nil(oldest_r)) chk_status = llq_pkg::STAT_EMPTY;
      end
      llq_pkg::OP_REMOVE_HANDLE: begin
        if (count_r == '0) begin
          chk_status = llq_pkg::STAT_EMPTY;
        end else if (!busy_r[handle_r]) begin
          chk_status = llq_pkg::STAT_BAD;
        end
      end
      llq_pkg::OP_READ_POS: begin
        if (count_r == '0) begin
          chk_status = llq_pkg::STAT_EMPTY;
        end else if (llq_pkg::LINK_W'(pos_r) >= count_r) begin
          chk_status = llq_pkg::STAT_BAD;
        end
      end
      default: chk_status = llq_pkg::STAT_OK;
    endcase
  end

  always_comb begin
    stat.opcode     = op_r;
    stat.chk_ok     = (chk_status == llq_pkg::STAT_OK);
    stat.walk_done  = walk_done;
    stat.list_empty = llq_pkg::is_nil(oldest_r);
    stat.out_stall  = out_valid_r && !out_ready;
  end

  // one write per link array per cycle
  always_comb begin
    nl_we   = 1'b0;
    nl_addr = cur_idx;
    nl_data = llq_pkg::NIL;
    pl_we   = 1'b0;
    pl_addr = cur_idx;
    pl_data = llq_pkg::NIL;
    case (cmd.op)
      llq_pkg::DP_APP_TAKE: begin
        nl_we   = 1'b1;
        pl_we   = 1'b1;
        pl_data = newest_r;
      end
      llq_pkg::DP_APP_LINK: begin
        nl_we   = !llq_pkg::is_nil(newest_r);
        nl_addr = newest_r[llq_pkg::NODE_W-1:0];
        nl_data = cur_r;
      end
      llq_pkg::DP_REL_UNLINK: begin
        nl_we   = !llq_pkg::is_nil(cur_older);
        nl_addr = cur_older[llq_pkg::NODE_W-1:0];
        nl_data = cur_newer;
        pl_we   = !llq_pkg::is_nil(cur_newer);
        pl_addr = cur_newer[llq_pkg::NODE_W-1:0];
        pl_data = cur_older;
      end
      llq_pkg::DP_REL_FREE: begin
        nl_we   = 1'b1;
        nl_data = free_top_r;
        pl_we   = 1'b1;
      end
      default: begin
        nl_we = 1'b0;
        pl_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < llq_pkg::POOL_NODES; i++) begin
        next_link_r[i] <= llq_pkg::link_t'(i + 1);
        prev_link_r[i] <= llq_pkg::NIL;
      end
    end else begin
      if (nl_we) next_link_r[nl_addr] <= nl_data;
      if (pl_we) prev_link_r[pl_addr] <= pl_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= '0;
      oldest_r   <= llq_pkg::NIL;
      newest_r   <= llq_pkg::NIL;
      free_top_r <= '0;
      count_r    <= '0;
    end else begin
      case (cmd.op)
        llq_pkg::DP_APP_TAKE: begin
          busy_r[cur_idx] <= 1'b1;
          free_top_r      <= cur_newer;
        end
        llq_pkg::DP_APP_LINK: begin
          if (llq_pkg::is_nil(newest_r)) oldest_r <= cur_r;
          newest_r <= cur_r;
          count_r  <= count_r + 1'b1;
        end
        llq_pkg::DP_REL_UNLINK: begin
          if (llq_pkg::is_nil(cur_older)) oldest_r <= cur_newer;
          if (llq_pkg::is_nil(cur_newer)) newest_r <= cur_older;
        end
        llq_pkg::DP_REL_FREE: begin
          busy_r[cur_idx] <= 1'b0;
          free_top_r      <= cur_r;
          if (count_r != '0) count_r <= count_r - 1'b1;
        end
        default: begin
          busy_r <= busy_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= '0;
      max_length_r  <= llq_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (llq_pkg::cfg_idx_t'(cfg_index))
        llq_pkg::CFG_MAX_ENTRIES: max_entries_r <= cfg_wdata[llq_pkg::ENT_W-1:0];
        llq_pkg::CFG_MAX_LENGTH:  max_length_r  <= cfg_wdata[llq_pkg::LEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == llq_pkg::DP_APP_TAKE) begin
      payload_mem[cur_idx] <= data_r;
      length_mem[cur_idx]  <= len_r;
    end
    rd_data_r <= payload_mem[cur_idx];
    rd_len_r  <= length_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= llq_pkg::op_t'(in_opcode);
      data_r   <= in_record_data;
      len_r    <= in_record_length;
      handle_r <= in_node_handle;
      pos_r    <= in_position;
    end
    case (cmd.op)
      llq_pkg::DP_CHECK: begin
        res_status_r <= chk_status;
        res_handle_r <= '0;
        idx_r        <= '0;
        if (op_r == llq_pkg::OP_APPEND) begin
          cur_r <= free_top_r;
        end else if (op_r == llq_pkg::OP_REMOVE_HANDLE) begin
          cur_r <= llq_pkg::link_t'(handle_r);
        end else begin
          cur_r <= oldest_r;
        end
      end
      llq_pkg::DP_APP_TAKE: res_handle_r <= cur_idx;
      llq_pkg::DP_SEL_OLDEST: cur_r <= oldest_r;
      llq_pkg::DP_WALK_STEP: begin
        cur_r <= cur_newer;
        idx_r <= idx_r + 1'b1;
      end
      llq_pkg::DP_WALK_END: begin
        if (llq_pkg::is_nil(cur_r)) begin
          res_status_r <= llq_pkg::STAT_BAD;
        end else begin
          res_handle_r <= cur_idx;
        end
      end
      llq_pkg::DP_EMIT: begin
        out_status_r <= res_status_r;
        out_handle_r <= res_handle_r;
        out_data_r   <= read_ok ? rd_data_r : '0;
        out_length_r <= read_ok ? rd_len_r : '0;
        out_count_r  <= count_r;
        out_empty_r  <= (count_r == '0);
        out_full_r   <= (count_r >= cap);
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == llq_pkg::DP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_handle     = out_handle_r;
  assign out_data       = out_data_r;
  assign out_length     = out_length_r;
  assign out_live_count = out_count_r;
  assign out_is_empty   = out_empty_r;
  assign out_is_full    = out_full_r;

endmodule

/* src/linked_list_queue_manager.sv */
// Top level of the linked-list queue manager: sequencer plus datapath.
// Depends on llq_pkg, llq_ctrl and llq_dp.
//
//   channel | ports                                           | handshake
//   --------+-------------------------------------------------+-------------------
//   input   | in_opcode, in_record_data, in_record_length,    | in_valid/in_ready
//           | in_node_handle, in_position                     |
//   result  | out_status, out_handle, out_data, out_length,   | out_valid/out_ready
//           | out_live_count, out_is_empty, out_is_full       |
//   config  | cfg_index, cfg_wdata                            | cfg_we, no stall
//
// A word is taken only while the sequencer is idle. A rejected or unused opcode goes from
// check to finish; append takes then links a node, both removes unlink then free one, a
// read walks to its position and a clear removes each entry in turn; the link arrays take
// one write per cycle. Reset is synchronous and restores the link chain and free list.
// A held result stalls only the finish step; the next word is taken after it leaves.
`timescale 1ns / 1ps

module linked_list_queue_manager (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [llq_pkg::OPC_W-1:0]         in_opcode,
  input  logic [llq_pkg::DATA_WIDTH-1:0]    in_record_data,
  input  logic [llq_pkg::LEN_W-1:0]         in_record_length,
  input  logic [llq_pkg::NODE_W-1:0]        in_node_handle,
  input  logic [llq_pkg::NODE_W-1:0]        in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [llq_pkg::STAT_W-1:0]        out_status,
  output logic [llq_pkg::NODE_W-1:0]        out_handle,
  output logic [llq_pkg::DATA_WIDTH-1:0]    out_data,
  output logic [llq_pkg::LEN_W-1:0]         out_length,
  output logic [llq_pkg::LINK_W-1:0]        out_live_count,
  output logic                              out_is_empty,
  output logic                              out_is_full,
  input  logic                              cfg_we,
  input  logic [llq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [llq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  llq_pkg::ctl_cmd_t cmd;
  llq_pkg::dp_stat_t stat;

  llq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  llq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_record_data   (in_record_data),
    .in_record_length (in_record_length),
    .in_node_handle   (in_node_handle),
    .in_position      (in_position),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_handle       (out_handle),
    .out_data         (out_data),
    .out_length       (out_length),
    .out_live_count   (out_live_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

endmodule

/* sim/tb.sv */
// Self-checking bench for linked_list_queue_manager: random and directed words through
// valid/ready channels, each result checked against an in-bench model of the node pool.
// Depends on llq_pkg and the linked_list_queue_manager RTL.
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT  = 4000;
  localparam int PHASES       = 9;
  localparam int PHASE_WORDS  = 128;
  localparam logic [llq_pkg::OPC_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [llq_pkg::OPC_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [llq_pkg::CFG_DATA_W-1:0] ENTRY_LIMITS [PHASES] =
    '{8'd16, 8'd1, 8'd2, 8'd5, 8'hFF, 8'd0, 8'd17, 8'd8, 8'd3};
  localparam logic [llq_pkg::CFG_DATA_W-1:0] LENGTH_LIMITS [PHASES] =
    '{8'd255, 8'd1, 8'd0, 8'd200, 8'd255, 8'd4, 8'd128, 8'd16, 8'd255};

  typedef struct packed {
    logic [llq_pkg::OPC_W-1:0]      opcode;
    logic [llq_pkg::DATA_WIDTH-1:0] data;
    logic [llq_pkg::LEN_W-1:0]      length;
    logic [llq_pkg::NODE_W-1:0]     handle;
    logic [llq_pkg::NODE_W-1:0]     position;
  } queue_word_t;

  typedef struct packed {
    llq_pkg::stat_t                 status;
    logic [llq_pkg::NODE_W-1:0]     handle;
    logic [llq_pkg::DATA_WIDTH-1:0] data;
    logic [llq_pkg::LEN_W-1:0]      length;
    logic [llq_pkg::LINK_W-1:0]     live;
    logic                           empty;
    logic                           full;
  } queue_result_t;

  typedef struct packed {
    logic [llq_pkg::POOL_NODES-1:0][llq_pkg::LINK_W-1:0]     newer;
    logic [llq_pkg::POOL_NODES-1:0][llq_pkg::LINK_W-1:0]     older;
    logic [llq_pkg::POOL_NODES-1:0][llq_pkg::DATA_WIDTH-1:0] data;
    logic [llq_pkg::POOL_NODES-1:0][llq_pkg::LEN_W-1:0]      length;
    logic [llq_pkg::POOL_NODES-1:0]                          busy;
    llq_pkg::link_t                                          oldest;
    llq_pkg::link_t                                          newest;
    llq_pkg::link_t                                          free_top;
    logic [llq_pkg::ENT_W-1:0]                               count;
  } node_pool_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [llq_pkg::OPC_W-1:0]      in_opcode = '0;
  logic [llq_pkg::DATA_WIDTH-1:0] in_record_data = '0;
  logic [llq_pkg::LEN_W-1:0]      in_record_length = '0;
  logic [llq_pkg::NODE_W-1:0]     in_node_handle = '0;
  logic [llq_pkg::NODE_W-1:0]     in_position = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [llq_pkg::STAT_W-1:0]     out_status;
  logic [llq_pkg::NODE_W-1:0]     out_handle;
  logic [llq_pkg::DATA_WIDTH-1:0] out_data;
  logic [llq_pkg::LEN_W-1:0]      out_length;
  logic [llq_pkg::LINK_W-1:0]     out_live_count;
  logic                           out_is_empty;
  logic                           out_is_full;
  logic                           cfg_we = 1'b0;
  logic [llq_pkg::CFG_IDX_W-1:0]  cfg_index = llq_pkg::CFG_MAX_ENTRIES;
  logic [llq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  queue_word_t   pending_words[$];
  queue_result_t expected_results[$];
  queue_word_t   held_word;
  node_pool_t    plan_pool;
  node_pool_t    dut_pool;
  logic [llq_pkg::ENT_W-1:0] cur_max_entries = '0;
  logic [llq_pkg::LEN_W-1:0] cur_max_length = llq_pkg::MAX_LENGTH_RST;
  int send_idle_pct = 16;
  int recv_idle_pct = 82;
  int err_count = 0;
  int quiet_cycles = 0;

  linked_list_queue_manager u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_record_data   (in_record_data),
    .in_record_length (in_record_length),
    .in_node_handle   (in_node_handle),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_handle       (out_handle),
    .out_data         (out_data),
    .out_length       (out_length),
    .out_live_count   (out_live_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic node_pool_t fresh_pool();
    node_pool_t p;
    int i;
    p = '0;
    for (i = 0; i < llq_pkg::POOL_NODES; i++) begin
      p.newer[i] = llq_pkg::link_t'(i + 1);
      p.older[i] = llq_pkg::NIL;
    end
    p.oldest   = llq_pkg::NIL;
    p.newest   = llq_pkg::NIL;
    p.free_top = '0;
    return p;
  endfunction

  function automatic int unsigned capacity_of(logic [llq_pkg::ENT_W-1:0] limit);
    if (limit == '0 || limit > llq_pkg::POOL_NODES) return llq_pkg::POOL_NODES;
    return 32'(limit);
  endfunction

  // unlink a busy node and push it onto the free list
  function automatic void free_node(inout node_pool_t p, input llq_pkg::link_t n);
    llq_pkg::link_t prv;
    llq_pkg::link_t nxt;
    if (n >= llq_pkg::NIL) return;
    prv = p.older[n[llq_pkg::NODE_W-1:0]];
    nxt = p.newer[n[llq_pkg::NODE_W-1:0]];
    if (prv < llq_pkg::NIL) p.newer[prv[llq_pkg::NODE_W-1:0]] = nxt;
    else p.oldest = nxt;
    if (nxt < llq_pkg::NIL) p.older[nxt[llq_pkg::NODE_W-1:0]] = prv;
    else p.newest = prv;
    p.newer[n[llq_pkg::NODE_W-1:0]] = p.free_top;
    p.older[n[llq_pkg::NODE_W-1:0]] = llq_pkg::NIL;
    p.free_top = n;
    p.busy[n[llq_pkg::NODE_W-1:0]] = 1'b0;
    if (p.count != '0) p.count = p.count - 1'b1;
  endfunction

  function automatic queue_result_t apply_word(inout node_pool_t p, input queue_word_t w,
                                               input logic [llq_pkg::ENT_W-1:0] max_ent,
                                               input logic [llq_pkg::LEN_W-1:0] max_len);
    queue_result_t r;
    llq_pkg::link_t n;
    int unsigned cap;
    int i;
    r = '0;
    cap = capacity_of(max_ent);
    case (w.opcode)
      llq_pkg::OP_APPEND: begin
        if (p.count >= cap || p.free_top >= llq_pkg::NIL) begin
          r.status = llq_pkg::STAT_FULL;
        end else if (w.length > max_len) begin
          r.status = llq_pkg::STAT_BAD;
        end else begin
          n = p.free_top;
          p.free_top = p.newer[n[llq_pkg::NODE_W-1:0]];
          p.data[n[llq_pkg::NODE_W-1:0]]   = w.data;
          p.length[n[llq_pkg::NODE_W-1:0]] = w.length;
          p.older[n[llq_pkg::NODE_W-1:0]]  = p.newest;
          p.newer[n[llq_pkg::NODE_W-1:0]]  = llq_pkg::NIL;
          if (p.newest < llq_pkg::NIL) p.newer[p.newest[llq_pkg::NODE_W-1:0]] = n;
          else p.oldest = n;
          p.newest = n;
          p.busy[n[llq_pkg::NODE_W-1:0]] = 1'b1;
          p.count = p.count + 1'b1;
          r.handle = n[llq_pkg::NODE_W-1:0];
        end
      end
      llq_pkg::OP_REMOVE_OLDEST: begin
        if (p.count == '0 || p.oldest >= llq_pkg::NIL) r.status = llq_pkg::STAT_EMPTY;
        else free_node(p, p.oldest);
      end
      llq_pkg::OP_REMOVE_HANDLE: begin
        if (p.count == '0) r.status = llq_pkg::STAT_EMPTY;
        else if (!p.busy[w.handle]) r.status = llq_pkg::STAT_BAD;
        else free_node(p, llq_pkg::link_t'(w.handle));
      end
      llq_pkg::OP_READ_POS: begin
        if (p.count == '0) begin
          r.status = llq_pkg::STAT_EMPTY;
        end else if (w.position >= p.count) begin
          r.status = llq_pkg::STAT_BAD;
        end else begin
          n = p.oldest;
          for (i = 0; i < llq_pkg::POOL_NODES; i++) begin
            if (i < w.position && n < llq_pkg::NIL) n = p.newer[n[llq_pkg::NODE_W-1:0]];
          end
          if (n >= llq_pkg::NIL) begin
            r.status = llq_pkg::STAT_BAD;
          end else begin
            r.handle = n[llq_pkg::NODE_W-1:0];
            r.data   = p.data[n[llq_pkg::NODE_W-1:0]];
            r.length = p.length[n[llq_pkg::NODE_W-1:0]];
          end
        end
      end
      llq_pkg::OP_CLEAR: begin
        for (i = 0; i < llq_pkg::POOL_NODES; i++) begin
          if (p.oldest < llq_pkg::NIL) free_node(p, p.oldest);
        end
      end
      default: ;
    endcase
    r.live  = p.count;
    r.empty = (p.count == '0);
    r.full  = (p.count >= cap);
    return r;
  endfunction

  task automatic push_word(input logic [llq_pkg::OPC_W-1:0] op,
                           input logic [llq_pkg::DATA_WIDTH-1:0] d,
                           input logic [llq_pkg::LEN_W-1:0] len,
                           input logic [llq_pkg::NODE_W-1:0] h,
                           input logic [llq_pkg::NODE_W-1:0] pos);
    queue_word_t w;
    w.opcode   = op;
    w.data     = d;
    w.length   = len;
    w.handle   = h;
    w.position = pos;
    void'(apply_word(plan_pool, w, cur_max_entries, cur_max_length));
    pending_words.push_back(w);
  endtask

  task automatic write_reg(input llq_pkg::cfg_idx_t idx,
                           input logic [llq_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == llq_pkg::CFG_MAX_ENTRIES) cur_max_entries = value[llq_pkg::ENT_W-1:0];
    else cur_max_length = value;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic compare_field(input string name,
                               input logic [llq_pkg::DATA_WIDTH-1:0] want,
                               input logic [llq_pkg::DATA_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_count++;
    end
  endtask

  // driver: hold the word until taken, then predict it
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_word(dut_pool, held_word, cur_max_entries,
                                              cur_max_length));
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          held_word = pending_words.pop_front();
          in_valid         <= 1'b1;
          in_opcode        <= held_word.opcode;
          in_record_data   <= held_word.data;
          in_record_length <= held_word.length;
          in_node_handle   <= held_word.handle;
          in_position      <= held_word.position;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("out_status: no result expected, actual %0h", out_status);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("out_status", llq_pkg::DATA_WIDTH'(want.status),
                        llq_pkg::DATA_WIDTH'(out_status));
          compare_field("out_handle", llq_pkg::DATA_WIDTH'(want.handle),
                        llq_pkg::DATA_WIDTH'(out_handle));
          compare_field("out_data", want.data, out_data);
          compare_field("out_length", llq_pkg::DATA_WIDTH'(want.length),
                        llq_pkg::DATA_WIDTH'(out_length));
          compare_field("out_live_count", llq_pkg::DATA_WIDTH'(want.live),
                        llq_pkg::DATA_WIDTH'(out_live_count));
          compare_field("out_is_empty", llq_pkg::DATA_WIDTH'(want.empty),
                        llq_pkg::DATA_WIDTH'(out_is_empty));
          compare_field("out_is_full", llq_pkg::DATA_WIDTH'(want.full),
                        llq_pkg::DATA_WIDTH'(out_is_full));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    int k;
    int i;
    int roll;
    int fill_pct;
    int pick;
    int idx;
    logic found;
    logic [llq_pkg::OPC_W-1:0]      op;
    logic [llq_pkg::DATA_WIDTH-1:0] d;
    logic [llq_pkg::LEN_W-1:0]      len;
    logic [llq_pkg::NODE_W-1:0]     h;
    logic [llq_pkg::NODE_W-1:0]     pos;

    plan_pool = fresh_pool();
    dut_pool  = fresh_pool();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty-queue cases, then a short fill, reads, removes and clear
    push_word(llq_pkg::OP_REMOVE_OLDEST, $urandom, 8'd0, 4'd0, 4'd0);
    push_word(llq_pkg::OP_REMOVE_HANDLE, $urandom, 8'd0, 4'd15, 4'd0);
    push_word(llq_pkg::OP_READ_POS, $urandom, 8'd0, 4'd0, 4'd0);
    push_word(llq_pkg::OP_CLEAR, $urandom, 8'd0, 4'd0, 4'd0);
    push_word(OP_SPARE_LO, $urandom, 8'd255, 4'd15, 4'd15);
    push_word(llq_pkg::OP_APPEND, $urandom, llq_pkg::MAX_LENGTH_RST + 8'd1, 4'd0, 4'd0);
    push_word(llq_pkg::OP_APPEND, '1, llq_pkg::MAX_LENGTH_RST, 4'd0, 4'd0);
    push_word(llq_pkg::OP_APPEND, '0, 8'd0, 4'd0, 4'd0);
    push_word(llq_pkg::OP_APPEND, $urandom, 8'd3, 4'd0, 4'd0);
    push_word(llq_pkg::OP_APPEND, $urandom, 8'd255, 4'd0, 4'd0);
    push_word(llq_pkg::OP_READ_POS, $urandom, 8'd0, 4'd0, 4'd0);
    push_word(llq_pkg::OP_READ_POS, $urandom, 8'd0, 4'd0, 4'd2);
    push_word(llq_pkg::OP_READ_POS, $urandom, 8'd0, 4'd0, 4'd3);
    push_word(llq_pkg::OP_READ_POS, $urandom, 8'd0, 4'd0, 4'd15);
    push_word(llq_pkg::OP_REMOVE_HANDLE, $urandom, 8'd0, 4'd15, 4'd0);
    push_word(llq_pkg::OP_REMOVE_HANDLE, $urandom, 8'd0, 4'd1, 4'd0);
    push_word(llq_pkg::OP_REMOVE_OLDEST, $urandom, 8'd0, 4'd0, 4'd0);
    push_word(OP_SPARE_HI, '1, 8'd0, 4'd0, 4'd0);
    push_word(llq_pkg::OP_APPEND, 32'hA5A5_5A5A, 8'd1, 4'd0, 4'd0);
    push_word(llq_pkg::OP_APPEND, $urandom, 8'd2, 4'd0, 4'd0);
    push_word(llq_pkg::OP_READ_POS, $urandom, 8'd0, 4'd0, 4'd1);
    push_word(llq_pkg::OP_CLEAR, $urandom, 8'd0, 4'd0, 4'd0);
    push_word(llq_pkg::OP_READ_POS, $urandom, 8'd0, 4'd0, 4'd0);
    push_word(llq_pkg::OP_APPEND, $urandom, llq_pkg::MAX_LENGTH_RST, 4'd0, 4'd0);
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = (phase < 3) ? 16 : (phase < 6) ? 82 : 0;
      recv_idle_pct = (phase < 3) ? 82 : (phase < 6) ? 16 : 0;
      write_reg(llq_pkg::CFG_MAX_ENTRIES, ENTRY_LIMITS[phase]);
      write_reg(llq_pkg::CFG_MAX_LENGTH, LENGTH_LIMITS[phase]);
      for (k = 0; k < PHASE_WORDS; k++) begin
        d   = $urandom;
        len = llq_pkg::LEN_W'($urandom_range(0, 255));
        h   = llq_pkg::NODE_W'($urandom_range(0, llq_pkg::POOL_NODES - 1));
        pos = llq_pkg::NODE_W'($urandom_range(0, llq_pkg::POOL_NODES - 1));
        if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 1) ? '1 : '0;
        fill_pct = ((k / 32) % 2 == 0) ? 55 : 25;
        roll = $urandom_range(0, 99);
        if (roll < fill_pct) begin
          op = llq_pkg::OP_APPEND;
          if ($urandom_range(0, 99) < 80) begin
            len = llq_pkg::LEN_W'($urandom_range(0, cur_max_length));
          end
        end else if (roll < fill_pct + 15) begin
          op = llq_pkg::OP_REMOVE_OLDEST;
        end else if (roll < fill_pct + 30) begin
          op = llq_pkg::OP_REMOVE_HANDLE;
          if (plan_pool.count != '0 && $urandom_range(0, 99) < 80) begin
            pick  = $urandom_range(0, llq_pkg::POOL_NODES - 1);
            found = 1'b0;
            for (i = 0; i < llq_pkg::POOL_NODES; i++) begin
              idx = (pick + i) % llq_pkg::POOL_NODES;
              if (!found && plan_pool.busy[idx]) begin
                h = llq_pkg::NODE_W'(idx);
                found = 1'b1;
              end
            end
          end
        end else if (roll < 98) begin
          op = llq_pkg::OP_READ_POS;
          if (plan_pool.count != '0 && $urandom_range(0, 99) < 85)
            pos = llq_pkg::NODE_W'($urandom_range(0, plan_pool.count - 1));
        end else if (roll == 98) begin
          op = llq_pkg::OP_CLEAR;
        end else begin
          op = OP_SPARE_LO + llq_pkg::OPC_W'($urandom_range(0, OP_SPARE_HI - OP_SPARE_LO));
        end
        push_word(op, d, len, h, pos);
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
